// ===== src/sorted_table_insert_search_macros.svh =====
// ----------------------------------------------------------------------------
// sorted table assertion macros
// shared concurrent assertion forms, clocked on clk with async reset arst_n
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_SEARCH_MACROS_SVH
`define SORTED_TABLE_INSERT_SEARCH_MACROS_SVH

// same-cycle implication
`define STIS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/stis_pkg.sv =====
// ----------------------------------------------------------------------------
// stis_pkg
// shared widths, operation codes and types of the sorted table
// ----------------------------------------------------------------------------
package stis_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 5;
	localparam int SUM_W     = 36;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SR_IDLE = 2'b01,
		SR_RUN  = 2'b10
	} srch_state_t;

	// per-cell compare flags against the incoming value
	typedef struct packed {
		logic le;
		logic gt;
		logic eq;
	} cell_cmp_t;

	// bisection result handed to the top level
	typedef struct packed {
		logic             done;
		logic             found;
		logic [POS_W-1:0] pos;
	} srch_res_t;

endpackage

// ===== src/stis_cell.sv =====
// ----------------------------------------------------------------------------
// stis_cell
// one table slot: holds an entry, compares it, shifts from its lower neighbor
// ----------------------------------------------------------------------------
module stis_cell (
	input  logic                             clk,
	input  logic                             occupied,
	input  logic                             ins_en,
	input  logic                             le_prev,
	input  logic signed [stis_pkg::VAL_W-1:0] prev_entry,
	input  logic signed [stis_pkg::VAL_W-1:0] value,
	output logic signed [stis_pkg::VAL_W-1:0] entry,
	output stis_pkg::cell_cmp_t               cmp
);
	import stis_pkg::*;

	logic signed [VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ins_en && !cmp.le) begin
			entry_q <= le_prev ? value : prev_entry;
		end
	end

	always_comb begin
		cmp.le = occupied && (entry_q <= value);
		cmp.gt = occupied && (value > entry_q);
		cmp.eq = occupied && (entry_q == value);
	end

	assign entry = entry_q;

endmodule

// ===== src/stis_search.sv =====
// ----------------------------------------------------------------------------
// stis_search
// bisection sequencer, one probe per cycle over latched compare flags
// ----------------------------------------------------------------------------
module stis_search #(
	parameter int TABLE_DEPTH = stis_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
	input  logic [TABLE_DEPTH-1:0]           gt_vec,
	input  logic [TABLE_DEPTH-1:0]           eq_vec,
	output logic                             idle,
	output stis_pkg::srch_res_t              res
);
	import stis_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int SW = CW + 2;

	srch_state_t             state_q;
	logic [TABLE_DEPTH-1:0]  gt_q;
	logic [TABLE_DEPTH-1:0]  eq_q;
	logic signed [SW-1:0]    lo_q;
	logic signed [SW-1:0]    hi_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [SW-1:0]    mid_sum;
	logic signed [SW-1:0]    mid;
	logic [IW-1:0]           mid_idx;
	logic                    live;
	logic                    hit;

	always_comb begin
		mid_sum = lo_q + hi_q;
		mid     = mid_sum >>> 1;
		mid_idx = mid[IW-1:0];
		live    = (lo_q <= hi_q);
		hit     = live && eq_q[mid_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
		end else begin
			unique case (state_q)
				SR_IDLE: begin
					if (start) begin
						state_q <= SR_RUN;
					end
				end
				SR_RUN: begin
					if (!live || hit) begin
						state_q <= SR_IDLE;
					end
				end
				default: state_q <= SR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SR_IDLE && start) begin
			gt_q  <= gt_vec;
			eq_q  <= eq_vec;
			lo_q  <= '0;
			hi_q  <= $signed({2'b00, count}) - SW'(1);
			pos_q <= '0;
		end else if (state_q == SR_RUN && live && !hit) begin
			pos_q <= mid[POS_W-1:0];
			if (gt_q[mid_idx]) begin
				lo_q <= mid + SW'(1);
			end else begin
				hi_q <= mid - SW'(1);
			end
		end
	end

	always_comb begin
		idle      = (state_q == SR_IDLE);
		res.done  = (state_q == SR_RUN) && (!live || hit);
		res.found = hit;
		res.pos   = live ? mid[POS_W-1:0] : pos_q;
	end

endmodule

// ===== src/sorted_table_insert_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// ascending table of signed values with ordered insert and bisection search
// ----------------------------------------------------------------------------
// usage:
//   input channel: operation, value with in_valid / in_stall; output channel:
//   found, position, rejected, entry_count, total_sum with out_valid /
//   out_stall. every input transfer gives exactly one output transfer.
//   insert: all cells compare against the value at once and shift larger
//   entries up in the same edge, so the result is registered in the cycle
//   after the transfer and the next item can follow in the next cycle
//   unless the receiver stalls. search: flags latched at the transfer, then
//   one bisection probe a cycle in stis_search; input is held off while
//   the probe loop runs. a waiting result does not block an insert: a new
//   item is taken when the output register is empty or being drained in
//   the same cycle. while the receiver stalls with a result pending,
//   in_stall stays high.
//   reset clears the entry count, the sum and all control state; stored
//   entries are not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
`include "sorted_table_insert_search_macros.svh"

module sorted_table_insert_search #(
	parameter int TABLE_DEPTH = stis_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [stis_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [stis_pkg::POS_W-1:0]        position,
	output logic                              rejected,
	output logic [stis_pkg::CNT_W-1:0]        entry_count,
	output logic signed [stis_pkg::SUM_W-1:0] total_sum
);
	import stis_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic signed [VAL_W-1:0] entry_w [TABLE_DEPTH];
	cell_cmp_t               cmp_w   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  gt_vec;
	logic [TABLE_DEPTH-1:0]  eq_vec;
	logic [CW-1:0]           count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [POS_W-1:0]        pos_q;
	logic                    rejected_q;
	logic                    accept;
	logic                    is_ins;
	logic                    full;
	logic                    ins_en;
	logic                    srch_start;
	logic                    srch_idle;
	srch_res_t               srch_res;
	logic [POS_W-1:0]        ins_pos;

	assign in_stall   = !srch_idle || (out_valid_q && out_stall);
	assign accept     = in_valid && !in_stall;
	assign is_ins     = (op_t'(operation) == OP_INSERT);
	assign full       = (count_q == CW'(TABLE_DEPTH));
	assign ins_en     = accept && is_ins && !full;
	assign srch_start = accept && !is_ins;

	// cell row
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic                    le_prev;
		logic signed [VAL_W-1:0] prev_entry;
		if (i == 0) begin : g_head
			assign le_prev    = 1'b0;
			assign prev_entry = value;
		end else begin : g_link
			assign le_prev    = cmp_w[i-1].le;
			assign prev_entry = entry_w[i-1];
		end
		stis_cell u_cell (
			.clk        (clk),
			.occupied   (CW'(i) < count_q),
			.ins_en     (ins_en),
			.le_prev    (le_prev),
			.prev_entry (prev_entry),
			.value      (value),
			.entry      (entry_w[i]),
			.cmp        (cmp_w[i])
		);
		assign gt_vec[i] = cmp_w[i].gt;
		assign eq_vec[i] = cmp_w[i].eq;
	end

	// insert slot: first cell that is empty or whose entry is above the value
	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!cmp_w[i].le && (i == 0 || cmp_w[(i == 0) ? 0 : i-1].le)) begin
				ins_pos = ins_pos | POS_W'(i);
			end
		end
	end

	stis_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (srch_start),
		.count  (count_q),
		.gt_vec (gt_vec),
		.eq_vec (eq_vec),
		.idle   (srch_idle),
		.res    (srch_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_en) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
			end
			if ((accept && is_ins) || srch_res.done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_ins) begin
			found_q    <= 1'b0;
			pos_q      <= full ? '0 : ins_pos;
			rejected_q <= full;
		end else if (srch_res.done) begin
			found_q    <= srch_res.found;
			pos_q      <= srch_res.pos;
			rejected_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign position    = pos_q;
	assign rejected    = rejected_q;
	assign entry_count = CNT_W'(count_q);
	assign total_sum   = sum_q;

	`STIS_ASSERT_SAME(a_no_accept_busy, accept, srch_idle, "item taken during search")
	`STIS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "count over depth")
	`STIS_ASSERT_NEXT(a_count_step, ins_en, count_q == $past(count_q) + CW'(1),
		"insert did not bump count")
	`STIS_ASSERT_SAME(a_reject_full, out_valid_q && rejected_q, full,
		"reject reported with room left")
	`STIS_ASSERT_SAME(a_done_slot, srch_res.done, !out_valid_q,
		"search finished over a pending result")

endmodule
